### sv/modbus_rtu_read_response_parser_defines.svh
// assertion macros used by the checker file mbrtu_checker.sv
`ifndef MODBUS_RTU_READ_RESPONSE_PARSER_DEFINES_SVH
`define MODBUS_RTU_READ_RESPONSE_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MBRTU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbrtu assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define MBRTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbrtu assertion failed");

`endif

### sv/mbrtu_pkg.sv
`default_nettype none

package mbrtu_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  ADDR_DEFAULT = 8'd1;

    typedef enum logic [2:0] {
        PH_ADDR   = 3'd0,
        PH_FUNC   = 3'd1,
        PH_COUNT  = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC_LO = 3'd4,
        PH_CRC_HI = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_CONSUMED = 3'd0,
        ST_PAYLOAD  = 3'd1,
        ST_OK       = 3'd2,
        ST_CRC_ERR  = 3'd3,
        ST_TIMEOUT  = 3'd4
    } status_t;

endpackage

`default_nettype wire

### sv/modbus_rtu_read_response_parser.sv
// an accepted input transaction passes the input register, then the result register; output stalls delay it
// throughput: one item per cycle while the output is not stalled; every item gives exactly one result
// rate is set by the input register, the combinational crc/phase update and the result register
// reset (rst_n low, asynchronous): parser waits for an address, crc 0xffff,
// counters and held fields 0, address register 1, both stages empty
`default_nettype none

module modbus_rtu_read_response_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                        // [23:16] func_code, [31:24] byte_count
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    // input stage
    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;

    // output stage
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_data_reg;

    // parser state
    logic [7:0]        server_addr_reg;
    mbrtu_pkg::phase_t phase_reg, phase_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        seen_reg, seen_next;
    logic [7:0]        count_reg, count_next;
    logic [7:0]        func_reg, func_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;

    mbrtu_pkg::status_t status;
    logic [7:0]         pbyte;
    logic [7:0]         pindex;
    logic [15:0]        crc_base;
    logic [15:0]        crc_fed;
    logic [7:0]         seen_inc;

    logic out_ready;
    logic advance;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign advance       = in_valid_reg && out_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_addr_reg <= mbrtu_pkg::ADDR_DEFAULT;
        end
        else if (cfg_wr_en)
        begin
            server_addr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    // crc continues inside a frame, restarts on an address byte
    assign crc_base = (phase_reg == mbrtu_pkg::PH_FUNC || phase_reg == mbrtu_pkg::PH_COUNT ||
                       phase_reg == mbrtu_pkg::PH_DATA) ? crc_reg : mbrtu_pkg::CRC_INIT;
    assign seen_inc = seen_reg + 8'd1;

    mbrtu_crc u_crc
    (
        .crc_in  (crc_base),
        .data    (in_byte_reg),
        .crc_out (crc_fed)
    );

    always_comb
    begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        seen_next   = seen_reg;
        count_next  = count_reg;
        func_next   = func_reg;
        crc_lo_next = crc_lo_reg;
        status      = mbrtu_pkg::ST_CONSUMED;
        pbyte       = 8'h00;
        pindex      = 8'h00;

        if (in_mode_reg)
        begin
            phase_next  = mbrtu_pkg::PH_ADDR;
            crc_next    = mbrtu_pkg::CRC_INIT;
            seen_next   = 8'h00;
            count_next  = 8'h00;
            func_next   = 8'h00;
            crc_lo_next = 8'h00;
            status      = mbrtu_pkg::ST_TIMEOUT;
        end
        else
        begin
            unique case (phase_reg)
                mbrtu_pkg::PH_FUNC:
                begin
                    func_next  = in_byte_reg;
                    crc_next   = crc_fed;
                    phase_next = mbrtu_pkg::PH_COUNT;
                end
                mbrtu_pkg::PH_COUNT:
                begin
                    count_next = in_byte_reg;
                    crc_next   = crc_fed;
                    seen_next  = 8'h00;
                    // empty data field goes straight to the crc
                    phase_next = (in_byte_reg == 8'h00) ? mbrtu_pkg::PH_CRC_LO
                                                        : mbrtu_pkg::PH_DATA;
                end
                mbrtu_pkg::PH_DATA:
                begin
                    crc_next  = crc_fed;
                    status    = mbrtu_pkg::ST_PAYLOAD;
                    pbyte     = in_byte_reg;
                    pindex    = seen_reg;
                    seen_next = seen_inc;
                    if (seen_inc == count_reg)
                    begin
                        phase_next = mbrtu_pkg::PH_CRC_LO;
                    end
                end
                mbrtu_pkg::PH_CRC_LO:
                begin
                    crc_lo_next = in_byte_reg;
                    phase_next  = mbrtu_pkg::PH_CRC_HI;
                end
                mbrtu_pkg::PH_CRC_HI:
                begin
                    status      = ({in_byte_reg, crc_lo_reg} == crc_reg) ? mbrtu_pkg::ST_OK
                                                                         : mbrtu_pkg::ST_CRC_ERR;
                    phase_next  = mbrtu_pkg::PH_ADDR;
                    crc_next    = mbrtu_pkg::CRC_INIT;
                    seen_next   = 8'h00;
                    crc_lo_next = 8'h00;
                end
                default:
                begin
                    // waiting for address, unused codes included
                    phase_next = mbrtu_pkg::PH_ADDR;
                    if (in_byte_reg == server_addr_reg)
                    begin
                        crc_next    = crc_fed;
                        seen_next   = 8'h00;
                        count_next  = 8'h00;
                        func_next   = 8'h00;
                        crc_lo_next = 8'h00;
                        phase_next  = mbrtu_pkg::PH_FUNC;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mbrtu_pkg::PH_ADDR;
            crc_reg    <= mbrtu_pkg::CRC_INIT;
            seen_reg   <= 8'h00;
            count_reg  <= 8'h00;
            func_reg   <= 8'h00;
            crc_lo_reg <= 8'h00;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            seen_reg   <= seen_next;
            count_reg  <= count_next;
            func_reg   <= func_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status;
            out_data_reg   <= {count_next, func_next, pindex, pbyte};
        end
    end

endmodule

`default_nettype wire

### sv/mbrtu_crc.sv
`default_nettype none

// one byte of crc-16, reflected polynomial, bitwise over eight steps
module mbrtu_crc
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    logic [15:0] crc_acc;

    always_comb
    begin
        crc_acc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (crc_acc[0])
            begin
                crc_acc = (crc_acc >> 1) ^ mbrtu_pkg::CRC_POLY;
            end
            else
            begin
                crc_acc = crc_acc >> 1;
            end
        end
        crc_out = crc_acc;
    end

endmodule

`default_nettype wire

### sv/mbrtu_checker.sv
`default_nettype none

`include "modbus_rtu_read_response_parser_defines.svh"

module mbrtu_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_wr_en,
    input wire logic [7:0]  cfg_wr_data,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    logic res_payload;
    logic res_timeout;

    assign res_payload = m_axis_tvalid && (m_axis_tuser == mbrtu_pkg::ST_PAYLOAD);
    assign res_timeout = m_axis_tvalid && (m_axis_tuser == mbrtu_pkg::ST_TIMEOUT);

    // a stalled result transaction holds
    `MBRTU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // timeout clears every field of its result
    `MBRTU_ASSERT_NOW(a_timeout_zero, res_timeout, m_axis_tdata == 32'h0)

    // payload byte and index are zero outside payload results
    `MBRTU_ASSERT_NOW(a_no_payload_zero, m_axis_tvalid && !res_payload, m_axis_tdata[15:0] == 16'h0)

    // payload index stays below the announced count
    `MBRTU_ASSERT_NOW(a_index_range, res_payload, m_axis_tdata[15:8] < m_axis_tdata[31:24])

endmodule

bind modbus_rtu_read_response_parser mbrtu_checker u_mbrtu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
